// File: rtl/vpt_pkg.sv
// shared types and constants for the vertex pose transform and color pack core
// no dependencies
`timescale 1ns / 1ps

package vpt_pkg;

  // register map, index = paddr[5:3]
  typedef enum logic [2:0] {
    REG_POS_X     = 3'd0,
    REG_POS_Y     = 3'd1,
    REG_POS_Z     = 3'd2,
    REG_SCALES    = 3'd3,
    REG_QUAT      = 3'd4,
    REG_DEF_COLOR = 3'd5,
    REG_USE_VC    = 3'd6
  } cfg_reg_t;

  localparam int ADDR_W  = 6;
  localparam int DATA_W  = 64;
  localparam int SCL_W   = 48;   // Q16.16 times Q8.8
  localparam int MAT_W   = 36;   // Q.28 rotation matrix entry
  localparam int ACC_W   = 88;   // Q.52 exact sum
  localparam int LZ_W    = 7;

  // depth of the color and sideband delay line, matched to the transform pipeline
  localparam int PIPE_DEPTH = 7;

  localparam logic [47:0] SCALES_RST  = 48'h0100_0101_0100;
  localparam logic [63:0] QUAT_RST    = 64'h4000_0000_0000_0000;
  localparam logic [63:0] DEFCOL_RST  = 64'h4000_4000_4000_4000;

endpackage

// File: rtl/vertex_pose_transform_color_pack_core.sv
// top level: config registers, scale/rotate/translate pipeline, float and color outputs
// depends on vpt_pkg, vpt_fconv, vpt_color
`timescale 1ns / 1ps

// Takes one vertex per clock: a transaction is accepted on any rising edge with start
// high and busy low, and busy is only high during reset. Each result shows up for one
// cycle with done high; the receiver cannot stall it. The seven stages are: scale
// multiply and rotation matrix build, split 24x36 partial products, product assembly,
// translation sum, then sign/magnitude, leading zero count and round/pack in the float
// converter. The user must write registers through the apb port (8-byte slots, 64-bit
// data) only while no transaction is in flight; the block does not enforce this.
module vertex_pose_transform_color_pack_core import vpt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // apb config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  // command side
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic signed [15:0] vertex_red,
  input  logic signed [15:0] vertex_green,
  input  logic signed [15:0] vertex_blue,
  input  logic signed [15:0] vertex_alpha,
  input  logic               last_in,
  // result side
  output logic               done,
  output logic [31:0]        world_x_bits,
  output logic [31:0]        world_y_bits,
  output logic [31:0]        world_z_bits,
  output logic [31:0]        rgba_bytes,
  output logic               last_out
);

  // config registers
  logic [31:0] position_x;
  logic [31:0] position_y;
  logic [31:0] position_z;
  logic [47:0] axis_scales;
  logic [63:0] rotation_quat;
  logic [63:0] default_color;
  logic        use_vertex_colors;

  cfg_reg_t reg_idx;
  logic     cfg_wr;
  logic     accept;

  assign pready  = 1'b1;
  assign busy    = rst;
  assign accept  = start && !busy;
  assign reg_idx = cfg_reg_t'(paddr[5:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      position_x        <= '0;
      position_y        <= '0;
      position_z        <= '0;
      axis_scales       <= SCALES_RST;
      rotation_quat     <= QUAT_RST;
      default_color     <= DEFCOL_RST;
      use_vertex_colors <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_POS_X:     position_x        <= pwdata[31:0];
        REG_POS_Y:     position_y        <= pwdata[31:0];
        REG_POS_Z:     position_z        <= pwdata[31:0];
        REG_SCALES:    axis_scales       <= pwdata[47:0];
        REG_QUAT:      rotation_quat     <= pwdata;
        REG_DEF_COLOR: default_color     <= pwdata;
        REG_USE_VC:    use_vertex_colors <= pwdata[0];
        default:       ;  // unmapped slot, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_POS_X:     prdata = 64'(position_x);
      REG_POS_Y:     prdata = 64'(position_y);
      REG_POS_Z:     prdata = 64'(position_z);
      REG_SCALES:    prdata = 64'(axis_scales);
      REG_QUAT:      prdata = rotation_quat;
      REG_DEF_COLOR: prdata = default_color;
      REG_USE_VC:    prdata = 64'(use_vertex_colors);
      default:       prdata = '0;
    endcase
  end

  // stage 1: per-axis scaling and the rotation matrix in Q.28
  logic signed [15:0] qx, qy, qz, qw;
  logic signed [32:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [MAT_W-1:0] mat_new [9];
  logic signed [SCL_W-1:0] s1_scl [3];
  logic signed [MAT_W-1:0] s1_mat [9];

  assign qx = rotation_quat[15:0];
  assign qy = rotation_quat[31:16];
  assign qz = rotation_quat[47:32];
  assign qw = rotation_quat[63:48];

  always_comb begin
    xx = 33'(qx * qx);
    yy = 33'(qy * qy);
    zz = 33'(qz * qz);
    xy = 33'(qx * qy);
    xz = 33'(qx * qz);
    yz = 33'(qy * qz);
    wx = 33'(qw * qx);
    wy = 33'(qw * qy);
    wz = 33'(qw * qz);
    mat_new[0] = MAT_W'(36'sd268435456) - (MAT_W'(yy + zz) <<< 1);
    mat_new[1] = MAT_W'(xy - wz) <<< 1;
    mat_new[2] = MAT_W'(xz + wy) <<< 1;
    mat_new[3] = MAT_W'(xy + wz) <<< 1;
    mat_new[4] = MAT_W'(36'sd268435456) - (MAT_W'(xx + zz) <<< 1);
    mat_new[5] = MAT_W'(yz - wx) <<< 1;
    mat_new[6] = MAT_W'(xz - wy) <<< 1;
    mat_new[7] = MAT_W'(yz + wx) <<< 1;
    mat_new[8] = MAT_W'(36'sd268435456) - (MAT_W'(xx + yy) <<< 1);
  end

  always_ff @(posedge clk) begin
    s1_scl[0] <= point_x * $signed(axis_scales[15:0]);
    s1_scl[1] <= point_y * $signed(axis_scales[31:16]);
    s1_scl[2] <= point_z * $signed(axis_scales[47:32]);
    for (int k = 0; k < 9; k++) s1_mat[k] <= mat_new[k];
  end

  // stage 2: each 48x36 product split in two 24-bit halves of the scaled point
  logic signed [60:0] s2_plo [9];
  logic signed [59:0] s2_phi [9];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s2_plo[i*3+j] <= $signed({1'b0, s1_scl[j][23:0]}) * s1_mat[i*3+j];
        s2_phi[i*3+j] <= $signed(s1_scl[j][47:24]) * s1_mat[i*3+j];
      end
    end
  end

  // stage 3: reassemble the full Q.52 products
  logic signed [ACC_W-1:0] s3_prod [9];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      s3_prod[k] <= (ACC_W'(s2_phi[k]) <<< 24) + ACC_W'(s2_plo[k]);
    end
  end

  // stage 4: add the translation, Q16.16 moved up 36 bits to Q.52
  logic signed [ACC_W-1:0] s4_acc [3];
  logic        [31:0]      pos    [3];

  assign pos[0] = position_x;
  assign pos[1] = position_y;
  assign pos[2] = position_z;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s4_acc[i] <= $signed({{20{pos[i][31]}}, pos[i], 36'd0})
                   + s3_prod[i*3] + s3_prod[i*3+1] + s3_prod[i*3+2];
    end
  end

  // stages 5 to 7: float conversion per axis
  vpt_fconv u_fconv_x (.clk(clk), .fixed_val(s4_acc[0]), .float_bits(world_x_bits));
  vpt_fconv u_fconv_y (.clk(clk), .fixed_val(s4_acc[1]), .float_bits(world_y_bits));
  vpt_fconv u_fconv_z (.clk(clk), .fixed_val(s4_acc[2]), .float_bits(world_z_bits));

  // color, last flag and transaction valid ride a matched delay line
  vpt_color u_color (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (accept),
    .use_vc   (use_vertex_colors),
    .def_color(default_color),
    .red      (vertex_red),
    .green    (vertex_green),
    .blue     (vertex_blue),
    .alpha    (vertex_alpha),
    .last_in  (last_in),
    .out_vld  (done),
    .rgba     (rgba_bytes),
    .last_out (last_out)
  );

`ifndef SYNTHESIS
  // every accepted transaction comes out a fixed latency later
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##7 done)
    else $error("result strobe missing after accepted transaction");

  // no denormals are produced: a zero exponent means a plain +0.0
  a_zero_x: assert property (@(posedge clk) disable iff (rst)
    (done && world_x_bits[30:23] == 8'd0) |-> world_x_bits == 32'd0)
    else $error("x result has zero exponent but is not +0.0");

  a_zero_z: assert property (@(posedge clk) disable iff (rst)
    (done && world_z_bits[30:23] == 8'd0) |-> world_z_bits == 32'd0)
    else $error("z result has zero exponent but is not +0.0");
`endif

endmodule

// File: rtl/vpt_fconv.sv
// fixed Q.52 to IEEE-754 single, round to nearest even, three register stages
// depends on vpt_pkg
`timescale 1ns / 1ps

module vpt_fconv import vpt_pkg::*; (
  input  logic                    clk,
  input  logic signed [ACC_W-1:0] fixed_val,
  output logic [31:0]             float_bits
);

  // two-level leading zero count: byte search then bit search
  function automatic logic [LZ_W-1:0] lzc(input logic [ACC_W-1:0] v);
    logic [LZ_W-1:0] n;
    logic [LZ_W-1:0] bl;
    logic            found;
    logic            hit;
    logic [7:0]      b;
    n = '0;
    bl = '0;
    found = 1'b0;
    hit = 1'b0;
    b = '0;
    for (int c = ACC_W / 8 - 1; c >= 0; c--) begin
      if (!found && v[c*8 +: 8] != 8'd0) begin
        found = 1'b1;
        b = v[c*8 +: 8];
        n = LZ_W'((ACC_W / 8 - 1 - c) * 8);
      end
    end
    for (int i = 7; i >= 0; i--) begin
      if (!hit && b[i]) begin
        hit = 1'b1;
      end else if (!hit) begin
        bl = bl + 1'b1;
      end
    end
    return n + bl;
  endfunction

  // stage a: sign and magnitude
  logic             a_sign;
  logic [ACC_W-1:0] a_mag;
  // stage b: leading zeros
  logic             b_sign;
  logic             b_zero;
  logic [ACC_W-1:0] b_mag;
  logic [LZ_W-1:0]  b_lz;

  logic [ACC_W-1:0] norm;
  logic [23:0]      mant;
  logic             rnd_bit;
  logic             sticky;
  logic [24:0]      mant_rnd;
  logic [7:0]       expo;

  always_ff @(posedge clk) begin
    a_sign <= fixed_val[ACC_W-1];
    a_mag  <= fixed_val[ACC_W-1] ? ACC_W'(-fixed_val) : ACC_W'(fixed_val);
  end

  always_ff @(posedge clk) begin
    b_sign <= a_sign;
    b_zero <= (a_mag == '0);
    b_mag  <= a_mag;
    b_lz   <= lzc(a_mag);
  end

  always_comb begin
    norm     = b_mag << b_lz;
    mant     = norm[ACC_W-1 -: 24];
    rnd_bit  = norm[ACC_W-25];
    sticky   = |norm[ACC_W-26:0];
    mant_rnd = {1'b0, mant} + 25'(rnd_bit && (sticky || mant[0]));
    // msb at bit 87-lz, value scale 2^-52, bias 127
    expo     = 8'(8'd162 - 8'(b_lz)) + 8'(mant_rnd[24]);
  end

  always_ff @(posedge clk) begin
    if (b_zero) begin
      float_bits <= 32'd0;
    end else begin
      float_bits <= {b_sign, expo, mant_rnd[24] ? 23'd0 : mant_rnd[22:0]};
    end
  end

endmodule

// File: rtl/vpt_color.sv
// color quantization and sideband delay line matching the transform latency
// depends on vpt_pkg
`timescale 1ns / 1ps

module vpt_color import vpt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_vld,
  input  logic        use_vc,
  input  logic [63:0] def_color,
  input  logic [15:0] red,
  input  logic [15:0] green,
  input  logic [15:0] blue,
  input  logic [15:0] alpha,
  input  logic        last_in,
  output logic        out_vld,
  output logic [31:0] rgba,
  output logic        last_out
);

  // clamp Q1.14 to [0,1], byte = (c*255 + 8192) >> 14
  function automatic logic [7:0] chan_byte(input logic [15:0] raw);
    logic [14:0] c;
    logic [22:0] p;
    if (raw[15]) begin
      c = '0;
    end else if (raw > 16'd16384) begin
      c = 15'd16384;
    end else begin
      c = raw[14:0];
    end
    p = 23'({c, 8'd0}) - 23'(c) + 23'd8192;
    return p[21:14];
  endfunction

  logic        vld_line  [PIPE_DEPTH];
  logic [31:0] rgba_line [PIPE_DEPTH];
  logic        last_line [PIPE_DEPTH];
  logic [31:0] rgba_new;

  always_comb begin
    if (use_vc) begin
      rgba_new = {chan_byte(alpha), chan_byte(blue), chan_byte(green), chan_byte(red)};
    end else begin
      rgba_new = {chan_byte(def_color[63:48]), chan_byte(def_color[47:32]),
                  chan_byte(def_color[31:16]), chan_byte(def_color[15:0])};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE_DEPTH; i++) vld_line[i] <= 1'b0;
    end else begin
      vld_line[0] <= in_vld;
      for (int i = 1; i < PIPE_DEPTH; i++) vld_line[i] <= vld_line[i-1];
    end
  end

  always_ff @(posedge clk) begin
    rgba_line[0] <= rgba_new;
    last_line[0] <= last_in;
    for (int i = 1; i < PIPE_DEPTH; i++) begin
      rgba_line[i] <= rgba_line[i-1];
      last_line[i] <= last_line[i-1];
    end
  end

  assign out_vld  = vld_line[PIPE_DEPTH-1];
  assign rgba     = rgba_line[PIPE_DEPTH-1];
  assign last_out = last_line[PIPE_DEPTH-1];

endmodule
